// ===== sv/sit_pkg.sv =====
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int ORIENT_WIDTH = PROD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0]  t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]   t_diff;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [ORIENT_WIDTH-1:0] t_orient;

    // point r inside the inclusive bounding range of p and q, one axis
    function automatic logic in_span(t_coord p, t_coord q, t_coord r);
        return ((p <= r) && (r <= q)) || ((q <= r) && (r <= p));
    endfunction

    // stage 1: edge vectors and offsets, bounding box results
    typedef struct packed {
        t_diff dxa;
        t_diff dya;
        t_diff dxb;
        t_diff dyb;
        t_diff b0y;
        t_diff b0x;
        t_diff b1y;
        t_diff b1x;
        t_diff a0y;
        t_diff a0x;
        t_diff a1y;
        t_diff a1x;
        logic  box_b0;
        logic  box_b1;
        logic  box_a0;
    } t_s1;

    // stage 2: cross product terms
    typedef struct packed {
        t_prod par_l;
        t_prod par_r;
        t_prod abb0_l;
        t_prod abb0_r;
        t_prod abb1_l;
        t_prod abb1_r;
        t_prod bba0_l;
        t_prod bba0_r;
        t_prod bba1_l;
        t_prod bba1_r;
        logic  box_b0;
        logic  box_b1;
        logic  box_a0;
    } t_s2;

    // stage 3: orientation signs and zero flags
    typedef struct packed {
        logic parallel;
        logic z_abb0;
        logic n_abb0;
        logic z_abb1;
        logic n_abb1;
        logic z_bba0;
        logic n_bba0;
        logic z_bba1;
        logic n_bba1;
        logic box_b0;
        logic box_b1;
        logic box_a0;
    } t_s3;

endpackage

// ===== sv/segment_intersection_test_core.sv =====
// channel | valid   | stall   | payload
// request | i_valid | o_stall | i_a_start_x .. i_b_end_y (signed coordinates)
// result  | o_valid | i_stall | o_segments_meet, o_directions_parallel
//
// four register stages: offsets and box compares, products, orientation
// signs, result register; one request per cycle while o_stall is low.
// each stage holds while the one after it is full and held, so bubbles close up
// and a stalled result does not block requests until the pipe is full.
// i_rst_n is synchronous, active low, and clears the valid bits only.
module segment_intersection_test_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sit_pkg::t_coord      i_a_start_x,
    input  sit_pkg::t_coord      i_a_start_y,
    input  sit_pkg::t_coord      i_a_end_x,
    input  sit_pkg::t_coord      i_a_end_y,
    input  sit_pkg::t_coord      i_b_start_x,
    input  sit_pkg::t_coord      i_b_start_y,
    input  sit_pkg::t_coord      i_b_end_x,
    input  sit_pkg::t_coord      i_b_end_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_segments_meet,
    output logic                 o_directions_parallel
);

    logic          r_v1, r_v2, r_v3, r_v4;
    sit_pkg::t_s1  r_s1, n_s1;
    sit_pkg::t_s2  r_s2, n_s2;
    sit_pkg::t_s3  r_s3, n_s3;
    logic          r_meet, n_meet;
    logic          r_par;
    logic          en1, en2, en3, en4;

    sit_pkg::t_orient o_abb0, o_abb1, o_bba0, o_bba1;

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    always_comb begin
        n_s1.dxa = sit_pkg::t_diff'(i_a_end_x) - sit_pkg::t_diff'(i_a_start_x);
        n_s1.dya = sit_pkg::t_diff'(i_a_end_y) - sit_pkg::t_diff'(i_a_start_y);
        n_s1.dxb = sit_pkg::t_diff'(i_b_end_x) - sit_pkg::t_diff'(i_b_start_x);
        n_s1.dyb = sit_pkg::t_diff'(i_b_end_y) - sit_pkg::t_diff'(i_b_start_y);
        n_s1.b0y = sit_pkg::t_diff'(i_b_start_y) - sit_pkg::t_diff'(i_a_start_y);
        n_s1.b0x = sit_pkg::t_diff'(i_b_start_x) - sit_pkg::t_diff'(i_a_start_x);
        n_s1.b1y = sit_pkg::t_diff'(i_b_end_y) - sit_pkg::t_diff'(i_a_start_y);
        n_s1.b1x = sit_pkg::t_diff'(i_b_end_x) - sit_pkg::t_diff'(i_a_start_x);
        n_s1.a0y = sit_pkg::t_diff'(i_a_start_y) - sit_pkg::t_diff'(i_b_start_y);
        n_s1.a0x = sit_pkg::t_diff'(i_a_start_x) - sit_pkg::t_diff'(i_b_start_x);
        n_s1.a1y = sit_pkg::t_diff'(i_a_end_y) - sit_pkg::t_diff'(i_b_start_y);
        n_s1.a1x = sit_pkg::t_diff'(i_a_end_x) - sit_pkg::t_diff'(i_b_start_x);
        n_s1.box_b0 = sit_pkg::in_span(i_a_start_x, i_a_end_x, i_b_start_x) &&
                      sit_pkg::in_span(i_a_start_y, i_a_end_y, i_b_start_y);
        n_s1.box_b1 = sit_pkg::in_span(i_a_start_x, i_a_end_x, i_b_end_x) &&
                      sit_pkg::in_span(i_a_start_y, i_a_end_y, i_b_end_y);
        n_s1.box_a0 = sit_pkg::in_span(i_b_start_x, i_b_end_x, i_a_start_x) &&
                      sit_pkg::in_span(i_b_start_y, i_b_end_y, i_a_start_y);
    end

    always_comb begin
        n_s2.par_l  = sit_pkg::t_prod'(r_s1.dya) * sit_pkg::t_prod'(r_s1.dxb);
        n_s2.par_r  = sit_pkg::t_prod'(r_s1.dyb) * sit_pkg::t_prod'(r_s1.dxa);
        n_s2.abb0_l = sit_pkg::t_prod'(r_s1.dxa) * sit_pkg::t_prod'(r_s1.b0y);
        n_s2.abb0_r = sit_pkg::t_prod'(r_s1.dya) * sit_pkg::t_prod'(r_s1.b0x);
        n_s2.abb1_l = sit_pkg::t_prod'(r_s1.dxa) * sit_pkg::t_prod'(r_s1.b1y);
        n_s2.abb1_r = sit_pkg::t_prod'(r_s1.dya) * sit_pkg::t_prod'(r_s1.b1x);
        n_s2.bba0_l = sit_pkg::t_prod'(r_s1.dxb) * sit_pkg::t_prod'(r_s1.a0y);
        n_s2.bba0_r = sit_pkg::t_prod'(r_s1.dyb) * sit_pkg::t_prod'(r_s1.a0x);
        n_s2.bba1_l = sit_pkg::t_prod'(r_s1.dxb) * sit_pkg::t_prod'(r_s1.a1y);
        n_s2.bba1_r = sit_pkg::t_prod'(r_s1.dyb) * sit_pkg::t_prod'(r_s1.a1x);
        n_s2.box_b0 = r_s1.box_b0;
        n_s2.box_b1 = r_s1.box_b1;
        n_s2.box_a0 = r_s1.box_a0;
    end

    always_comb begin
        o_abb0 = sit_pkg::t_orient'(r_s2.abb0_l) - sit_pkg::t_orient'(r_s2.abb0_r);
        o_abb1 = sit_pkg::t_orient'(r_s2.abb1_l) - sit_pkg::t_orient'(r_s2.abb1_r);
        o_bba0 = sit_pkg::t_orient'(r_s2.bba0_l) - sit_pkg::t_orient'(r_s2.bba0_r);
        o_bba1 = sit_pkg::t_orient'(r_s2.bba1_l) - sit_pkg::t_orient'(r_s2.bba1_r);
        n_s3.parallel = (r_s2.par_l == r_s2.par_r);
        n_s3.z_abb0 = (o_abb0 == '0);
        n_s3.n_abb0 = o_abb0[sit_pkg::ORIENT_WIDTH-1];
        n_s3.z_abb1 = (o_abb1 == '0);
        n_s3.n_abb1 = o_abb1[sit_pkg::ORIENT_WIDTH-1];
        n_s3.z_bba0 = (o_bba0 == '0);
        n_s3.n_bba0 = o_bba0[sit_pkg::ORIENT_WIDTH-1];
        n_s3.z_bba1 = (o_bba1 == '0);
        n_s3.n_bba1 = o_bba1[sit_pkg::ORIENT_WIDTH-1];
        n_s3.box_b0 = r_s2.box_b0;
        n_s3.box_b1 = r_s2.box_b1;
        n_s3.box_a0 = r_s2.box_a0;
    end

    // non-parallel: sign product <= 0, either zero or signs differ; parallel: zero turn and inside the box
    always_comb begin
        if (r_s3.parallel) begin
            n_meet = (r_s3.z_abb0 && r_s3.box_b0) ||
                     (r_s3.z_abb1 && r_s3.box_b1) ||
                     (r_s3.z_bba0 && r_s3.box_a0);
        end else begin
            n_meet = (r_s3.z_bba0 || r_s3.z_bba1 || (r_s3.n_bba0 != r_s3.n_bba1)) &&
                     (r_s3.z_abb0 || r_s3.z_abb1 || (r_s3.n_abb0 != r_s3.n_abb1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
        if (en2) r_s2 <= n_s2;
        if (en3) r_s3 <= n_s3;
        if (en4) begin
            r_meet <= n_meet;
            r_par  <= r_s3.parallel;
        end
    end

    assign o_valid               = r_v4;
    assign o_segments_meet       = r_meet;
    assign o_directions_parallel = r_par;

endmodule

// ===== verif/segment_intersection_test_core_tb.sv =====
`timescale 1ns / 1ps

module segment_intersection_test_core_tb;

    typedef struct packed {
        sit_pkg::t_coord ax0;
        sit_pkg::t_coord ay0;
        sit_pkg::t_coord ax1;
        sit_pkg::t_coord ay1;
        sit_pkg::t_coord bx0;
        sit_pkg::t_coord by0;
        sit_pkg::t_coord bx1;
        sit_pkg::t_coord by1;
    } t_seg_pair;

    typedef struct packed {
        logic meet;
        logic parallel;
    } t_verdict;

    class meet_scoreboard;
        t_verdict pending_verdicts[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // cross product of (q - p) and (r - p)
        function longint turn(longint px, longint py, longint qx, longint qy,
                              longint rx, longint ry);
            return (qx - px) * (ry - py) - (qy - py) * (rx - px);
        endfunction

        function int sgn(longint v);
            return int'(v > 0) - int'(v < 0);
        endfunction

        function bit lies_on(longint px, longint py, longint qx, longint qy,
                             longint rx, longint ry);
            longint lox = (px < qx) ? px : qx;
            longint hix = (px < qx) ? qx : px;
            longint loy = (py < qy) ? py : qy;
            longint hiy = (py < qy) ? qy : py;
            if (turn(px, py, qx, qy, rx, ry) != 0)
                return 1'b0;
            return (rx >= lox) && (rx <= hix) && (ry >= loy) && (ry <= hiy);
        endfunction

        function t_verdict judge_pair(t_seg_pair p);
            longint   ax0 = p.ax0;
            longint   ay0 = p.ay0;
            longint   ax1 = p.ax1;
            longint   ay1 = p.ay1;
            longint   bx0 = p.bx0;
            longint   by0 = p.by0;
            longint   bx1 = p.bx1;
            longint   by1 = p.by1;
            t_verdict v;
            int       s1, s2, s3, s4;
            v.parallel = ((ay1 - ay0) * (bx1 - bx0)) == ((by1 - by0) * (ax1 - ax0));
            if (v.parallel) begin
                v.meet = lies_on(ax0, ay0, ax1, ay1, bx0, by0) ||
                         lies_on(ax0, ay0, ax1, ay1, bx1, by1) ||
                         lies_on(bx0, by0, bx1, by1, ax0, ay0);
            end else begin
                s1 = sgn(turn(bx0, by0, bx1, by1, ax0, ay0));
                s2 = sgn(turn(bx0, by0, bx1, by1, ax1, ay1));
                s3 = sgn(turn(ax0, ay0, ax1, ay1, bx0, by0));
                s4 = sgn(turn(ax0, ay0, ax1, ay1, bx1, by1));
                v.meet = (s1 * s2 <= 0) && (s3 * s4 <= 0);
            end
            return v;
        endfunction

        function void note_pair(t_seg_pair p);
            pending_verdicts = {pending_verdicts, judge_pair(p)};
        endfunction

        function void check_verdict(logic meet, logic parallel);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, meet %0b parallel %0b",
                         $time, meet, parallel);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (meet !== want.meet) begin
                $display("%0t: segments_meet expected %0b actual %0b",
                         $time, want.meet, meet);
                errors++;
            end
            if (parallel !== want.parallel) begin
                $display("%0t: directions_parallel expected %0b actual %0b",
                         $time, want.parallel, parallel);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_stall = 1'b0;
    sit_pkg::t_coord i_a_start_x = '0;
    sit_pkg::t_coord i_a_start_y = '0;
    sit_pkg::t_coord i_a_end_x = '0;
    sit_pkg::t_coord i_a_end_y = '0;
    sit_pkg::t_coord i_b_start_x = '0;
    sit_pkg::t_coord i_b_start_y = '0;
    sit_pkg::t_coord i_b_end_x = '0;
    sit_pkg::t_coord i_b_end_y = '0;
    logic            o_stall;
    logic            o_valid;
    logic            o_segments_meet;
    logic            o_directions_parallel;

    logic      steady = 1'b0;
    t_seg_pair req_now;
    meet_scoreboard sb;

    segment_intersection_test_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_a_start_x           (i_a_start_x),
        .i_a_start_y           (i_a_start_y),
        .i_a_end_x             (i_a_end_x),
        .i_a_end_y             (i_a_end_y),
        .i_b_start_x           (i_b_start_x),
        .i_b_start_y           (i_b_start_y),
        .i_b_end_x             (i_b_end_x),
        .i_b_end_y             (i_b_end_y),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_segments_meet       (o_segments_meet),
        .o_directions_parallel (o_directions_parallel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    assign req_now = {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
                      i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y};

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_pair(req_now);
            if (o_valid && !i_stall)
                sb.check_verdict(o_segments_meet, o_directions_parallel);
        end
    end

    function automatic t_seg_pair mk(int ax0, int ay0, int ax1, int ay1,
                                     int bx0, int by0, int bx1, int by1);
        t_seg_pair p;
        p.ax0 = sit_pkg::t_coord'(ax0);
        p.ay0 = sit_pkg::t_coord'(ay0);
        p.ax1 = sit_pkg::t_coord'(ax1);
        p.ay1 = sit_pkg::t_coord'(ay1);
        p.bx0 = sit_pkg::t_coord'(bx0);
        p.by0 = sit_pkg::t_coord'(by0);
        p.bx1 = sit_pkg::t_coord'(bx1);
        p.by1 = sit_pkg::t_coord'(by1);
        return p;
    endfunction

    function automatic int rnd_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int corner_coord();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // points along one line through a base point
    function automatic t_seg_pair collinear_pair(int span);
        int bx = rnd_in(-1000, 1000);
        int by = rnd_in(-1000, 1000);
        int dx = rnd_in(-5, 5);
        int dy = rnd_in(-5, 5);
        int k0 = rnd_in(-span, span);
        int k1 = rnd_in(-span, span);
        int k2 = rnd_in(-span, span);
        int k3 = rnd_in(-span, span);
        return mk(bx + dx * k0, by + dy * k0, bx + dx * k1, by + dy * k1,
                  bx + dx * k2, by + dy * k2, bx + dx * k3, by + dy * k3);
    endfunction

    function automatic t_seg_pair random_pair();
        t_seg_pair p;
        int        dx, dy;
        case ($urandom_range(9)) inside
            0, 1, 2: begin
                p = mk($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom());
            end
            3, 4: begin
                p = mk(rnd_in(-8, 7), rnd_in(-8, 7), rnd_in(-8, 7), rnd_in(-8, 7),
                       rnd_in(-8, 7), rnd_in(-8, 7), rnd_in(-8, 7), rnd_in(-8, 7));
            end
            5: begin
                p = mk(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                       corner_coord(), corner_coord(), corner_coord(), corner_coord());
            end
            6: begin
                p = collinear_pair(20);
            end
            7: begin
                // one endpoint of b copied from a
                p = mk(rnd_in(-200, 200), rnd_in(-200, 200), rnd_in(-200, 200),
                       rnd_in(-200, 200), rnd_in(-200, 200), rnd_in(-200, 200),
                       rnd_in(-200, 200), rnd_in(-200, 200));
                case ($urandom_range(3))
                    0: begin p.bx0 = p.ax0; p.by0 = p.ay0; end
                    1: begin p.bx0 = p.ax1; p.by0 = p.ay1; end
                    2: begin p.bx1 = p.ax0; p.by1 = p.ay0; end
                    default: begin p.bx1 = p.ax1; p.by1 = p.ay1; end
                endcase
            end
            8: begin
                // b is a shifted copy of a, possibly reversed
                p = mk(rnd_in(-2000, 2000), rnd_in(-2000, 2000), rnd_in(-2000, 2000),
                       rnd_in(-2000, 2000), rnd_in(-2000, 2000), rnd_in(-2000, 2000),
                       0, 0);
                dx = int'(p.ax1) - int'(p.ax0);
                dy = int'(p.ay1) - int'(p.ay0);
                if ($urandom_range(1)) begin
                    dx = -dx;
                    dy = -dy;
                end
                p.bx1 = sit_pkg::t_coord'(int'(p.bx0) + dx);
                p.by1 = sit_pkg::t_coord'(int'(p.by0) + dy);
            end
            default: begin
                // point segments, on or just off the other one
                p = collinear_pair(6);
                case ($urandom_range(2))
                    0: begin p.ax1 = p.ax0; p.ay1 = p.ay0; end
                    1: begin p.bx1 = p.bx0; p.by1 = p.by0; end
                    default: begin
                        p.ax1 = p.ax0; p.ay1 = p.ay0;
                        p.bx1 = p.bx0; p.by1 = p.by0;
                    end
                endcase
                if ($urandom_range(3) == 0)
                    p.ax0 = sit_pkg::t_coord'(int'(p.ax0) + 1);
            end
        endcase
        return p;
    endfunction

    task automatic drive_pair(t_seg_pair p);
        while (!steady && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_a_start_x <= p.ax0;
        i_a_start_y <= p.ay0;
        i_a_end_x   <= p.ax1;
        i_a_end_y   <= p.ay1;
        i_b_start_x <= p.bx0;
        i_b_start_y <= p.by0;
        i_b_end_x   <= p.bx1;
        i_b_end_y   <= p.by1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_pair(mk(-10, -10, 10, 10, -10, 10, 10, -10));
        drive_pair(mk(0, 0, 4, 0, 5, 1, 6, 5));
        drive_pair(mk(0, 0, 10, 0, 5, 0, 5, 7));
        drive_pair(mk(0, 0, 3, 3, 3, 3, 6, 0));
        drive_pair(mk(0, 0, 10, 0, 5, 1, 5, 7));
        // collinear: overlap, gap, shared end, b covering a; then parallel but offset
        drive_pair(mk(0, 0, 10, 10, 5, 5, 20, 20));
        drive_pair(mk(0, 0, 2, 2, 3, 3, 5, 5));
        drive_pair(mk(0, 0, 2, 2, 2, 2, 5, 5));
        drive_pair(mk(2, 2, 3, 3, 0, 0, 9, 9));
        drive_pair(mk(0, 0, 4, 2, 0, 1, 4, 3));
        // point segments
        drive_pair(mk(3, 3, 3, 3, 0, 0, 6, 6));
        drive_pair(mk(3, 4, 3, 4, 0, 0, 6, 6));
        drive_pair(mk(0, 0, 6, 6, 4, 4, 4, 4));
        drive_pair(mk(7, -7, 7, -7, 7, -7, 7, -7));
        drive_pair(mk(7, -7, 7, -7, 7, -6, 7, -6));
        // full-scale coordinates
        drive_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        drive_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        drive_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        drive_pair(mk(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768));
        drive_pair(mk(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32766));
        drive_pair(mk(-32768, -32768, 32767, -32767, 32767, 32767, -32768, 32766));
        drive_pair(mk(32767, -32768, -32768, 32767, 0, 0, -1, -1));

        for (int n = 0; n < 1000; n++) begin
            steady <= (n >= 400) && (n < 650);
            drive_pair(random_pair());
        end
        steady  <= 1'b0;
        i_valid <= 1'b0;

        // let the last request reach the scoreboard before draining
        @(negedge i_clk);
        while (sb.pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
